@@ src/tlca_pkg.sv @@
// ---------------------------------------------------------------------------
// tlca_pkg
// Shared types and constants for the binary-lifting ancestor unit: field
// widths, table geometry, action and status codes and the beat structs.
// ---------------------------------------------------------------------------
package tlca_pkg;

    // Node and table geometry
    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = 4;
    localparam int CNT_W     = 11;
    localparam int DEPTH_W   = 10;
    localparam int DIST_W    = 12;
    localparam int ENTRY_W   = NODE_W + 1;
    localparam int JT_AW     = LVL_W + NODE_W;
    localparam int JT_DEPTH  = LEVELS * MAX_NODES;

    // Action codes
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_BUILD = 3'd1;
    localparam logic [2:0] ACT_LCA   = 3'd2;
    localparam logic [2:0] ACT_PATH  = 3'd3;
    localparam logic [2:0] ACT_TRI   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_NO_ANC    = 2'd2;

    // Register indexes
    localparam logic CFG_ROOT  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_c;
        logic [NODE_W-1:0] parent_node;
        logic              has_parent;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic [DIST_W-1:0] distance;
        logic              on_path;
        logic [1:0]        status;
    } out_item_t;

endpackage

@@ src/tree_lca_binary_lifting_unit.sv @@
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting_unit
// Binary-lifting lowest common ancestor engine. Parents and the doubling
// table live in one synchronous RAM, node depths in a second one; a
// sequencer walks them with at most one read per cycle.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | tlca_pkg::in_item_t
//  out     | output    | out_valid / out_stall| tlca_pkg::out_item_t
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Query: one node pair for an ancestor query, three for a path test or
//  three-node distance. The table RAM has one read port, so its reads are
//  issued one at a time.
//  After reset, level 0 of the table is cleared, one entry a cycle;
//  in_stall stays high meanwhile.
//  A new item is taken while the previous result waits in the output register.
// ---------------------------------------------------------------------------
module tree_lca_binary_lifting_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  tlca_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tlca_pkg::out_item_t      out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [tlca_pkg::CNT_W-1:0] cfg_data
);

    localparam int NW = tlca_pkg::NODE_W;
    localparam int KW = tlca_pkg::LVL_W;
    localparam int CW = tlca_pkg::CNT_W;
    localparam int DW = tlca_pkg::DEPTH_W;
    localparam int EW = tlca_pkg::ENTRY_W;
    localparam int AW = tlca_pkg::JT_AW;
    localparam logic [KW-1:0] K_TOP  = KW'(tlca_pkg::LEVELS - 1);
    localparam logic [KW-1:0] K_LAST = KW'(tlca_pkg::LEVELS - 2);
    localparam logic [CW-1:0] N_MAX  = CW'(tlca_pkg::MAX_NODES);

    // Sequencer states
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_LOAD    = 5'd2;
    localparam logic [4:0] S_RESP    = 5'd3;
    localparam logic [4:0] S_BC_RD   = 5'd4;
    localparam logic [4:0] S_BC_WR   = 5'd5;
    localparam logic [4:0] S_BL_RD0  = 5'd6;
    localparam logic [4:0] S_BL_RD1  = 5'd7;
    localparam logic [4:0] S_BL_WR   = 5'd8;
    localparam logic [4:0] S_BD_INIT = 5'd9;
    localparam logic [4:0] S_BD_RD   = 5'd10;
    localparam logic [4:0] S_BD_STEP = 5'd11;
    localparam logic [4:0] S_BD_WR   = 5'd12;
    localparam logic [4:0] S_Q_PAIR  = 5'd13;
    localparam logic [4:0] S_L_RDU   = 5'd14;
    localparam logic [4:0] S_L_RDV   = 5'd15;
    localparam logic [4:0] S_L_SWAP  = 5'd16;
    localparam logic [4:0] S_L_LIFT  = 5'd17;
    localparam logic [4:0] S_L_LIFTW = 5'd18;
    localparam logic [4:0] S_L_CMP   = 5'd19;
    localparam logic [4:0] S_L_UPRU  = 5'd20;
    localparam logic [4:0] S_L_UPRV  = 5'd21;
    localparam logic [4:0] S_L_UPCK  = 5'd22;
    localparam logic [4:0] S_L_FIN   = 5'd23;
    localparam logic [4:0] S_L_FINW  = 5'd24;
    localparam logic [4:0] S_L_DA    = 5'd25;
    localparam logic [4:0] S_L_DIST  = 5'd26;
    localparam logic [4:0] S_Q_END   = 5'd27;

    // Memories
    logic [EW-1:0] jt_mem [tlca_pkg::JT_DEPTH];
    logic [DW-1:0] dep_mem [tlca_pkg::MAX_NODES];

    logic          jt_we;
    logic [AW-1:0] jt_waddr;
    logic [EW-1:0] jt_wdata;
    logic [AW-1:0] jt_raddr;
    logic [EW-1:0] jt_q;
    logic          dep_we;
    logic [NW-1:0] dep_waddr;
    logic [DW-1:0] dep_wdata;
    logic [NW-1:0] dep_raddr;
    logic [DW-1:0] dep_q;

    // Control registers
    logic [4:0]          state_reg, state_next;
    logic                built_reg, built_next;
    logic [NW-1:0]       root_reg, root_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       v_reg, v_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [1:0]          pair_reg, pair_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    tlca_pkg::in_item_t  item_reg, item_next;
    tlca_pkg::out_item_t res_reg, res_next;
    tlca_pkg::out_item_t out_reg, out_next;
    logic [NW-1:0]       nu_reg, nu_next;
    logic [NW-1:0]       nv_reg, nv_next;
    logic [DW-1:0]       du_reg, du_next;
    logic [DW-1:0]       dv_reg, dv_next;
    logic [DW-1:0]       diff_reg, diff_next;
    logic [EW-1:0]       pu_reg, pu_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [DW-1:0]       dacc_reg, dacc_next;
    logic [NW-1:0]       anc_reg, anc_next;
    logic [DW:0]         d1_reg, d1_next;
    logic [DW:0]         d2_reg, d2_next;
    logic [DW:0]         d3_reg, d3_next;

    // Datapath helpers
    logic [CW-1:0]       used_n;
    logic                range_bad;
    logic [DW:0]         dsum;
    logic [DW:0]         dtwice;
    logic [DW:0]         dval;
    logic [DW+2:0]       tri_sum;
    logic [DW+1:0]       side_sum;

    assign used_n = (count_reg > N_MAX) ? N_MAX : count_reg;
    assign range_bad = ({1'b0, in_data.node_a} >= used_n)
                    || ({1'b0, in_data.node_b} >= used_n)
                    || ((in_data.action != tlca_pkg::ACT_LCA)
                        && ({1'b0, in_data.node_c} >= used_n));

    // Pair distance: du + dv - 2*d(anc), floored at zero
    assign dsum   = {1'b0, du_reg} + {1'b0, dv_reg};
    assign dtwice = {dep_q, 1'b0};
    assign dval   = (dsum < dtwice) ? '0 : (dsum - dtwice);
    assign tri_sum  = {2'b00, d1_reg} + {2'b00, d2_reg} + {2'b00, d3_reg};
    assign side_sum = {1'b0, d2_reg} + {1'b0, d3_reg};

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Table RAM: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (jt_we)
        begin
            jt_mem[jt_waddr] <= jt_wdata;
        end
        jt_q <= jt_mem[jt_raddr];
    end

    // Depth RAM
    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
        dep_q <= dep_mem[dep_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        root_next      = root_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        pair_next      = pair_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        nu_next        = nu_reg;
        nv_next        = nv_reg;
        du_next        = du_reg;
        dv_next        = dv_reg;
        diff_next      = diff_reg;
        pu_next        = pu_reg;
        cur_next       = cur_reg;
        dacc_next      = dacc_reg;
        anc_next       = anc_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        d3_next        = d3_reg;
        jt_we          = 1'b0;
        jt_waddr       = '0;
        jt_wdata       = '0;
        jt_raddr       = '0;
        dep_we         = 1'b0;
        dep_waddr      = '0;
        dep_wdata      = '0;
        dep_raddr      = '0;

        // Output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes invalidate the table
        if (cfg_valid)
        begin
            if (cfg_index == tlca_pkg::CFG_ROOT)
            begin
                root_next = cfg_data[NW-1:0];
            end
            else
            begin
                count_next = cfg_data;
            end
            built_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                jt_we    = 1'b1;
                jt_waddr = {{KW{1'b0}}, clr_reg};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(tlca_pkg::MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    if (in_data.action == tlca_pkg::ACT_LOAD)
                    begin
                        built_next = 1'b0;
                        state_next = S_LOAD;
                    end
                    else if (in_data.action == tlca_pkg::ACT_BUILD)
                    begin
                        n_next     = used_n;
                        v_next     = '0;
                        state_next = S_BC_RD;
                    end
                    else if (in_data.action == tlca_pkg::ACT_LCA
                          || in_data.action == tlca_pkg::ACT_PATH
                          || in_data.action == tlca_pkg::ACT_TRI)
                    begin
                        if (!built_reg)
                        begin
                            res_next.status = tlca_pkg::ST_NOT_BUILT;
                            state_next      = S_RESP;
                        end
                        else if (range_bad)
                        begin
                            res_next.status = tlca_pkg::ST_NO_ANC;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            pair_next  = '0;
                            state_next = S_Q_PAIR;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_LOAD:
            begin
                jt_we      = 1'b1;
                jt_waddr   = {{KW{1'b0}}, item_reg.node_a};
                jt_wdata   = item_reg.has_parent ? {1'b1, item_reg.parent_node} : '0;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            // Build: drop root parent and out-of-range parents
            S_BC_RD:
            begin
                if (v_reg == n_reg)
                begin
                    v_next     = '0;
                    k_next     = '0;
                    state_next = (tlca_pkg::LEVELS > 1) ? S_BL_RD0 : S_BD_INIT;
                end
                else
                begin
                    jt_raddr   = {{KW{1'b0}}, v_reg[NW-1:0]};
                    state_next = S_BC_WR;
                end
            end
            S_BC_WR:
            begin
                if (v_reg[NW-1:0] == root_reg || !jt_q[EW-1]
                    || {1'b0, jt_q[NW-1:0]} >= n_reg)
                begin
                    jt_we    = 1'b1;
                    jt_waddr = {{KW{1'b0}}, v_reg[NW-1:0]};
                end
                v_next     = v_reg + 1'b1;
                state_next = S_BC_RD;
            end
            // Build: level k+1 from two hops at level k
            S_BL_RD0:
            begin
                if (v_reg == n_reg)
                begin
                    v_next = '0;
                    if (k_reg == K_LAST)
                    begin
                        state_next = S_BD_INIT;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    jt_raddr   = {k_reg, v_reg[NW-1:0]};
                    state_next = S_BL_RD1;
                end
            end
            S_BL_RD1:
            begin
                pu_next    = jt_q;
                jt_raddr   = {k_reg, jt_q[NW-1:0]};
                state_next = S_BL_WR;
            end
            S_BL_WR:
            begin
                jt_we      = 1'b1;
                jt_waddr   = {k_reg + 1'b1, v_reg[NW-1:0]};
                jt_wdata   = (pu_reg[EW-1] && jt_q[EW-1]) ? {1'b1, jt_q[NW-1:0]} : '0;
                v_next     = v_reg + 1'b1;
                state_next = S_BL_RD0;
            end
            // Build: depth by jumping from the top level down
            S_BD_INIT:
            begin
                if (v_reg == n_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cur_next   = v_reg[NW-1:0];
                    dacc_next  = '0;
                    k_next     = K_TOP;
                    state_next = S_BD_RD;
                end
            end
            S_BD_RD:
            begin
                jt_raddr   = {k_reg, cur_reg};
                state_next = S_BD_STEP;
            end
            S_BD_STEP:
            begin
                if (jt_q[EW-1])
                begin
                    cur_next  = jt_q[NW-1:0];
                    dacc_next = dacc_reg | (DW'(1) << k_reg);
                end
                if (k_reg == '0)
                begin
                    state_next = S_BD_WR;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_BD_RD;
                end
            end
            S_BD_WR:
            begin
                dep_we     = 1'b1;
                dep_waddr  = v_reg[NW-1:0];
                dep_wdata  = dacc_reg;
                v_next     = v_reg + 1'b1;
                state_next = S_BD_INIT;
            end
            // Query: choose the node pair for this pass
            S_Q_PAIR:
            begin
                nu_next = item_reg.node_a;
                nv_next = item_reg.node_b;
                if (pair_reg == 2'd1)
                begin
                    if (item_reg.action == tlca_pkg::ACT_PATH)
                    begin
                        nv_next = item_reg.node_c;
                    end
                    else
                    begin
                        nu_next = item_reg.node_b;
                        nv_next = item_reg.node_c;
                    end
                end
                else if (pair_reg == 2'd2)
                begin
                    nu_next = item_reg.node_c;
                    nv_next = (item_reg.action == tlca_pkg::ACT_PATH)
                            ? item_reg.node_b : item_reg.node_a;
                end
                state_next = S_L_RDU;
            end
            S_L_RDU:
            begin
                dep_raddr  = nu_reg;
                state_next = S_L_RDV;
            end
            S_L_RDV:
            begin
                dep_raddr  = nv_reg;
                du_next    = dep_q;
                state_next = S_L_SWAP;
            end
            S_L_SWAP:
            begin
                dv_next = dep_q;
                if (du_reg < dep_q)
                begin
                    nu_next   = nv_reg;
                    nv_next   = nu_reg;
                    diff_next = dep_q - du_reg;
                end
                else
                begin
                    diff_next = du_reg - dep_q;
                end
                k_next     = '0;
                state_next = S_L_LIFT;
            end
            // Lift the deeper node by the depth difference
            S_L_LIFT:
            begin
                if (diff_reg[k_reg])
                begin
                    jt_raddr   = {k_reg, nu_reg};
                    state_next = S_L_LIFTW;
                end
                else if (k_reg == K_TOP)
                begin
                    state_next = S_L_CMP;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_L_LIFTW:
            begin
                if (!jt_q[EW-1])
                begin
                    res_next        = '0;
                    res_next.status = tlca_pkg::ST_NO_ANC;
                    state_next      = S_RESP;
                end
                else
                begin
                    nu_next = jt_q[NW-1:0];
                    if (k_reg == K_TOP)
                    begin
                        state_next = S_L_CMP;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_L_LIFT;
                    end
                end
            end
            S_L_CMP:
            begin
                if (nu_reg == nv_reg)
                begin
                    anc_next   = nu_reg;
                    state_next = S_L_DA;
                end
                else
                begin
                    k_next     = K_TOP;
                    state_next = S_L_UPRU;
                end
            end
            // Climb both nodes while their ancestors differ
            S_L_UPRU:
            begin
                jt_raddr   = {k_reg, nu_reg};
                state_next = S_L_UPRV;
            end
            S_L_UPRV:
            begin
                pu_next    = jt_q;
                jt_raddr   = {k_reg, nv_reg};
                state_next = S_L_UPCK;
            end
            S_L_UPCK:
            begin
                if (pu_reg[EW-1] && jt_q[EW-1] && pu_reg[NW-1:0] != jt_q[NW-1:0])
                begin
                    nu_next = pu_reg[NW-1:0];
                    nv_next = jt_q[NW-1:0];
                end
                if (k_reg == '0)
                begin
                    state_next = S_L_FIN;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_L_UPRU;
                end
            end
            S_L_FIN:
            begin
                jt_raddr   = {{KW{1'b0}}, nu_reg};
                state_next = S_L_FINW;
            end
            S_L_FINW:
            begin
                if (!jt_q[EW-1])
                begin
                    res_next        = '0;
                    res_next.status = tlca_pkg::ST_NO_ANC;
                    state_next      = S_RESP;
                end
                else
                begin
                    anc_next   = jt_q[NW-1:0];
                    state_next = S_L_DA;
                end
            end
            S_L_DA:
            begin
                dep_raddr  = anc_reg;
                state_next = S_L_DIST;
            end
            S_L_DIST:
            begin
                if (pair_reg == 2'd0)
                begin
                    d1_next               = dval;
                    res_next.ancestor     = anc_reg;
                end
                else if (pair_reg == 2'd1)
                begin
                    d2_next = dval;
                end
                else
                begin
                    d3_next = dval;
                end
                if (item_reg.action == tlca_pkg::ACT_LCA || pair_reg == 2'd2)
                begin
                    state_next = S_Q_END;
                end
                else
                begin
                    pair_next  = pair_reg + 1'b1;
                    state_next = S_Q_PAIR;
                end
            end
            S_Q_END:
            begin
                if (item_reg.action == tlca_pkg::ACT_TRI)
                begin
                    res_next.distance = tri_sum[DW+2:1];
                end
                else
                begin
                    res_next.distance = {1'b0, d1_reg};
                end
                if (item_reg.action == tlca_pkg::ACT_PATH)
                begin
                    res_next.on_path = (side_sum == {1'b0, d1_reg});
                end
                state_next = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            built_reg     <= 1'b0;
            root_reg      <= '0;
            count_reg     <= N_MAX;
            n_reg         <= '0;
            v_reg         <= '0;
            k_reg         <= '0;
            clr_reg       <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            root_reg      <= root_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            v_reg         <= v_next;
            k_reg         <= k_next;
            clr_reg       <= clr_next;
            pair_reg      <= pair_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        nu_reg   <= nu_next;
        nv_reg   <= nv_next;
        du_reg   <= du_next;
        dv_reg   <= dv_next;
        diff_reg <= diff_next;
        pu_reg   <= pu_next;
        cur_reg  <= cur_next;
        dacc_reg <= dacc_next;
        anc_reg  <= anc_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        d3_reg   <= d3_next;
    end

    // Checks
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != tlca_pkg::ST_OK)
            |-> (out_data.ancestor == '0 && out_data.distance == '0 && !out_data.on_path))
        else $error("failed result carries nonzero fields");

    a_onpath_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.on_path) |-> (out_data.status == tlca_pkg::ST_OK))
        else $error("on_path set on a failed result");

    a_not_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && res_reg.status == tlca_pkg::ST_NOT_BUILT) |-> !built_reg)
        else $error("not-built status while table is built");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_TOP)
        else $error("level counter out of range");

    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg <= n_reg)
        else $error("node sweep passed the node count");

endmodule
